>>> rtl/gmbe_pkg.sv
// Package: shared types, constants and the control program of the block encoder.
`timescale 1ns / 1ps
package gmbe_pkg;

  // Field and register widths
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned INDEX_W  = 17;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned BLEN_W   = 5;
  localparam int unsigned DIM_W    = 4;
  localparam int unsigned ALPH_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 16;

  // Largest code size q^k that is still encoded
  localparam logic [INDEX_W-1:0] CODE_LIMIT = 17'd100000;
  // Running power q^i, one multiply beyond the limit at most
  localparam int unsigned TOTAL_W = INDEX_W + ALPH_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH  = 2'd0,
    REG_DIMENSION     = 2'd1,
    REG_ALPHABET_SIZE = 2'd2
  } cfg_reg_e;

  // Input item kinds
  typedef enum logic {
    ITEM_WRITE  = 1'b0,
    ITEM_ENCODE = 1'b1
  } item_e;

  // Program steps
  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_POW  = 4'd1,
    ST_CHK  = 4'd2,
    ST_DIG  = 4'd3,
    ST_DIGW = 4'd4,
    ST_DIGS = 4'd5,
    ST_SYM  = 4'd6,
    ST_MAC  = 4'd7,
    ST_MOD  = 4'd8,
    ST_MODW = 4'd9,
    ST_EMIT = 4'd10,
    ST_NEXT = 4'd11,
    ST_LOOP = 4'd12,
    ST_ERR  = 4'd13,
    ST_RET  = 4'd14
  } step_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_POW,
    OP_CHECK,
    OP_DIV_INDEX,
    OP_DIGIT_STORE,
    OP_SYMINIT,
    OP_MAC,
    OP_DIV_ACC,
    OP_EMIT,
    OP_NEXTCOL,
    OP_ERROR
  } op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ENCODE,
    C_POW_MORE,
    C_BAD,
    C_BUSY,
    C_MORE_DIG,
    C_MORE_ROW,
    C_OUT_FULL,
    C_LAST_COL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
  } ctrl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic no_encode;
    logic pow_more;
    logic bad;
    logic div_busy;
    logic more_dig;
    logic more_row;
    logic out_full;
    logic last_col;
  } dp_status_t;

  // Control store: taken when the condition holds, else fall through
  function automatic ctrl_word_t micro_rom(step_e pc);
    ctrl_word_t w;
    unique case (pc)
      ST_IDLE: w = '{op: OP_ACCEPT,      cond: C_NO_ENCODE, target: ST_IDLE};
      ST_POW:  w = '{op: OP_POW,         cond: C_POW_MORE,  target: ST_POW};
      ST_CHK:  w = '{op: OP_CHECK,       cond: C_BAD,       target: ST_ERR};
      ST_DIG:  w = '{op: OP_DIV_INDEX,   cond: C_NONE,      target: ST_IDLE};
      ST_DIGW: w = '{op: OP_NOP,         cond: C_BUSY,      target: ST_DIGW};
      ST_DIGS: w = '{op: OP_DIGIT_STORE, cond: C_MORE_DIG,  target: ST_DIG};
      ST_SYM:  w = '{op: OP_SYMINIT,     cond: C_NONE,      target: ST_IDLE};
      ST_MAC:  w = '{op: OP_MAC,         cond: C_MORE_ROW,  target: ST_MAC};
      ST_MOD:  w = '{op: OP_DIV_ACC,     cond: C_NONE,      target: ST_IDLE};
      ST_MODW: w = '{op: OP_NOP,         cond: C_BUSY,      target: ST_MODW};
      ST_EMIT: w = '{op: OP_EMIT,        cond: C_OUT_FULL,  target: ST_EMIT};
      ST_NEXT: w = '{op: OP_NEXTCOL,     cond: C_LAST_COL,  target: ST_IDLE};
      ST_LOOP: w = '{op: OP_NOP,         cond: C_ALWAYS,    target: ST_SYM};
      ST_ERR:  w = '{op: OP_ERROR,       cond: C_OUT_FULL,  target: ST_ERR};
      ST_RET:  w = '{op: OP_NOP,         cond: C_ALWAYS,    target: ST_IDLE};
      default: w = '{op: OP_NOP,         cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/gmbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gmbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gmbe_divider.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder.
`timescale 1ns / 1ps
module gmbe_divider #(
  parameter int unsigned DW = 21,
  parameter int unsigned VW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [VW-1:0]    div_q, div_d;
  logic [VW:0]      trial;
  logic [VW:0]      diff;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial   = {rem_q, quo_q[DW-1]};
    diff    = trial - {1'b0, div_q};
    count_d = count_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      count_d = CNT_W'(DW);
      quo_d   = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (count_q != '0) begin
      count_d = count_q - 1'b1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o      = (count_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/gmbe_sequencer.sv
// Step counter over the control store, with conditional jumps.
`timescale 1ns / 1ps
module gmbe_sequencer import gmbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_word_t ctrl_o
);

  step_e      pc_q, pc_d;
  ctrl_word_t word;
  logic       jump;

  // Fetch the control word of the current step
  always_comb begin
    word   = micro_rom(pc_q);
    ctrl_o = word;
  end

  // Evaluate the jump condition and pick the next step
  always_comb begin
    unique case (word.cond)
      C_NONE:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_ENCODE: jump = status_i.no_encode;
      C_POW_MORE:  jump = status_i.pow_more;
      C_BAD:       jump = status_i.bad;
      C_BUSY:      jump = status_i.div_busy;
      C_MORE_DIG:  jump = status_i.more_dig;
      C_MORE_ROW:  jump = status_i.more_row;
      C_OUT_FULL:  jump = status_i.out_full;
      C_LAST_COL:  jump = status_i.last_col;
      default:     jump = 1'b1;
    endcase
    pc_d = jump ? word.target : step_e'(pc_q + 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> rtl/generator_matrix_block_encoder_unit.sv
// Top level of the generator-table block encoder: datapath and channel logic.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: row, column, entry_value,
//                                              message_index; tuser: op
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: symbol, position;
//                                              tlast: last; tuser: error
//  cfg       in   cfg_we_i                     cfg_index_i, cfg_data_i
//
// Each digit of the message index is extracted, and each symbol sum reduced, by the
// bit-serial divider, whose width DW is 21 bits by default.
// The table is read one row per cycle through a registered RAM port.
// Reset returns the step counter to idle and loads the register defaults; the
// table holds nothing defined until written. A stalled result holds the program
// at the emit or error step; no new item is taken until the encode has issued its last beat.
`timescale 1ns / 1ps
module generator_matrix_block_encoder_unit import gmbe_pkg::*; #(
  parameter int unsigned MAX_LENGTH    = 16,
  parameter int unsigned MAX_DIMENSION = 8,
  parameter int unsigned SYMBOL_BITS   = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: row[2:0], column[6:3], entry_value[14:7], message_index[31:15]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // tuser: op
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: symbol[7:0], position[11:8], zero fill[15:12]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  output logic                  m_axis_tlast,
  // tuser: error
  output logic                  m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_DIMENSION * MAX_LENGTH;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW     = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned RW     = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned NW     = $clog2(MAX_LENGTH + 1);
  localparam int unsigned JW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned PROD_W = ALPH_W + SYMBOL_BITS;
  localparam int unsigned ACC_W  = PROD_W + KW;
  localparam int unsigned DW     = (ACC_W > INDEX_W) ? ACC_W : INDEX_W;
  localparam logic [16:0] Q_HI   = 17'(1) << SYMBOL_BITS;

  // Configuration registers
  logic [BLEN_W-1:0] blen_q;
  logic [DIM_W-1:0]  dim_q;
  logic [ALPH_W-1:0] alph_q;

  // Datapath registers
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [KW-1:0]      cnt_q, cnt_d;
  logic [JW-1:0]      j_q, j_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ALPH_W-1:0]  digits_q [MAX_DIMENSION];
  logic               digit_we;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [SYM_W-1:0]  out_sym_q, out_sym_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_last_q, out_last_d;
  logic              out_err_q, out_err_d;
  logic              out_free;

  // Input fields
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic [ENTRY_W-1:0] in_entry;
  logic [INDEX_W-1:0] in_index;
  logic               in_fire;
  logic [23:0]        entry_ext;

  // Effective code parameters
  logic [KW-1:0]     k_eff;
  logic [NW-1:0]     n_eff;
  logic [ALPH_W-1:0] q_eff;

  ctrl_word_t ctrl;
  dp_status_t status;

  // Table port signals
  logic                   tbl_we;
  logic [ADDR_W-1:0]      tbl_waddr;
  logic [ADDR_W-1:0]      tbl_raddr;
  logic [SYMBOL_BITS-1:0] tbl_wdata;
  logic [SYMBOL_BITS-1:0] tbl_rdata;
  int unsigned            rd_row;

  // Divider signals
  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic              div_busy;
  logic [DW-1:0]     div_quo;
  logic [ALPH_W-1:0] div_rem;

  logic [PROD_W-1:0]      product;
  logic [TOTAL_W-1:0]     pow_next;
  logic [ALPH_W-1:0]      digit_cur;

  assign in_row    = s_axis_tdata[2:0];
  assign in_col    = s_axis_tdata[6:3];
  assign in_entry  = s_axis_tdata[14:7];
  assign in_index  = s_axis_tdata[31:15];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign entry_ext = {16'd0, in_entry};

  assign s_axis_tready = (ctrl.op == OP_ACCEPT);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Saturate the registers into their usable ranges
  always_comb begin
    if (dim_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(dim_q) > MAX_DIMENSION) begin
      k_eff = KW'(MAX_DIMENSION);
    end else begin
      k_eff = KW'(dim_q);
    end
    if (blen_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(blen_q) > MAX_LENGTH) begin
      n_eff = NW'(MAX_LENGTH);
    end else begin
      n_eff = NW'(blen_q);
    end
    if (alph_q < ALPH_W'(2)) begin
      q_eff = ALPH_W'(2);
    end else if (17'(alph_q) > Q_HI) begin
      q_eff = Q_HI[ALPH_W-1:0];
    end else begin
      q_eff = alph_q;
    end
  end

  // Hold configuration; the user must write only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= BLEN_W'(7);
      dim_q  <= DIM_W'(4);
      alph_q <= ALPH_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BLOCK_LENGTH:  blen_q <= cfg_data_i[BLEN_W-1:0];
        REG_DIMENSION:     dim_q  <= cfg_data_i[DIM_W-1:0];
        REG_ALPHABET_SIZE: alph_q <= cfg_data_i[ALPH_W-1:0];
        default:           ;
      endcase
    end
  end

  // Table write on an accepted write beat inside the table
  assign tbl_we    = in_fire && (s_axis_tuser == ITEM_WRITE) &&
                     (32'(in_row) < MAX_DIMENSION) && (32'(in_col) < MAX_LENGTH);
  assign tbl_waddr = ADDR_W'(32'(in_row) * MAX_LENGTH + 32'(in_col));
  assign tbl_wdata = entry_ext[SYMBOL_BITS-1:0];

  // Read the row that the next multiply-accumulate step needs
  always_comb begin
    rd_row    = (ctrl.op == OP_SYMINIT) ? 0 : 32'(cnt_q) + 1;
    tbl_raddr = ADDR_W'(rd_row * MAX_LENGTH + 32'(j_q));
  end

  gmbe_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign div_start    = (ctrl.op == OP_DIV_INDEX) || (ctrl.op == OP_DIV_ACC);
  assign div_dividend = (ctrl.op == OP_DIV_ACC) ? DW'(acc_q) : DW'(idx_q);

  gmbe_divider #(
    .DW (DW),
    .VW (ALPH_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (q_eff),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Flags for the sequencer
  always_comb begin
    status.no_encode = !(in_fire && (s_axis_tuser == ITEM_ENCODE));
    status.pow_more  = (cnt_q < k_eff) && (total_q <= TOTAL_W'(CODE_LIMIT));
    status.bad       = (total_q > TOTAL_W'(CODE_LIMIT)) || (TOTAL_W'(idx_q) >= total_q);
    status.div_busy  = div_busy;
    status.more_dig  = (32'(cnt_q) + 1 < 32'(k_eff));
    status.more_row  = (32'(cnt_q) + 1 < 32'(k_eff));
    status.out_full  = !out_free;
    status.last_col  = (32'(j_q) + 1 == 32'(n_eff));
  end

  gmbe_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign digit_cur = digits_q[cnt_q[RW-1:0]];
  assign product   = digit_cur * tbl_rdata;
  assign pow_next  = total_q[INDEX_W-1:0] * q_eff;

  // Datapath operations of each step
  always_comb begin
    idx_d       = idx_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    acc_d       = acc_q;
    digit_we    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_sym_d   = out_sym_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (in_fire && (s_axis_tuser == ITEM_ENCODE)) begin
          idx_d   = in_index;
          total_d = TOTAL_W'(1);
          cnt_d   = '0;
        end
      end
      OP_POW: begin
        if (status.pow_more) begin
          total_d = pow_next;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      OP_CHECK: begin
        cnt_d = '0;
        j_d   = '0;
      end
      OP_DIGIT_STORE: begin
        digit_we = 1'b1;
        idx_d    = div_quo[INDEX_W-1:0];
        cnt_d    = cnt_q + 1'b1;
      end
      OP_SYMINIT: begin
        acc_d = '0;
        cnt_d = '0;
      end
      OP_MAC: begin
        acc_d = acc_q + ACC_W'(product);
        cnt_d = cnt_q + 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = SYM_W'(div_rem);
          out_pos_d   = POS_W'(j_q);
          out_last_d  = status.last_col;
          out_err_d   = 1'b0;
        end
      end
      OP_NEXTCOL: begin
        j_d = j_q + 1'b1;
      end
      OP_ERROR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = '0;
          out_pos_d   = '0;
          out_last_d  = 1'b0;
          out_err_d   = 1'b1;
        end
      end
      OP_NOP, OP_DIV_INDEX, OP_DIV_ACC: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    total_q    <= total_d;
    cnt_q      <= cnt_d;
    j_q        <= j_d;
    acc_q      <= acc_d;
    out_sym_q  <= out_sym_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
    if (digit_we) begin
      digits_q[cnt_q[RW-1:0]] <= div_rem;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_pos_q, out_sym_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

endmodule

>>> rtl/gmbe_checker.sv
// Port-level checks of the block encoder, bound to the top level.
`timescale 1ns / 1ps
module gmbe_checker import gmbe_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_DATA_W-1:0]   m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  m_axis_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // An error beat carries nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("error beat with payload or last");

  // An accepted encode keeps the input closed on the next cycle
  a_encode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ITEM_ENCODE) |=> !s_axis_tready)
    else $error("input open right after an encode beat");

  // More symbols follow a beat that is not last, so the input stays closed
  a_mid_codeword: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast && !m_axis_tuser |=> !s_axis_tready)
    else $error("input open in the middle of a codeword");

endmodule

bind generator_matrix_block_encoder_unit gmbe_checker u_gmbe_checker (.*);

>>> dv/gmbe_codeword_checker.sv
// Checker: follows the encoder channels, predicts each codeword and compares result beats.
`timescale 1ns / 1ps
module gmbe_codeword_checker import gmbe_pkg::*; #(
  parameter int unsigned MAX_LENGTH    = 16,
  parameter int unsigned MAX_DIMENSION = 8,
  parameter int unsigned SYMBOL_BITS   = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata: row[2:0], column[6:3], entry_value[14:7], message_index[31:15]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // tuser: op
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: symbol[7:0], position[11:8], zero fill[15:12]
  input  logic [M_DATA_W-1:0]   m_axis_tdata,
  input  logic                  m_axis_tlast,
  // tuser: error
  input  logic                  m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_beats_o
);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
    logic             last;
    logic             error;
  } codeword_beat_t;

  // Shadow copy of the code registers and the generator table
  logic [BLEN_W-1:0]  length_q;
  logic [DIM_W-1:0]   dim_q;
  logic [ALPH_W-1:0]  alph_q;
  logic [ENTRY_W-1:0] gen_table [MAX_DIMENSION][MAX_LENGTH];
  codeword_beat_t     codeword_beats_q[$];

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                              int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expand one message index into the beats the encoder must emit
  function automatic void predict_codeword(logic [INDEX_W-1:0] msg);
    int unsigned    n, k, q, code_size, rest, acc;
    int unsigned    digit [MAX_DIMENSION];
    codeword_beat_t beat;
    n = clamp_range(length_q, 1, MAX_LENGTH);
    k = clamp_range(dim_q, 1, MAX_DIMENSION);
    q = clamp_range(alph_q, 2, 1 << SYMBOL_BITS);
    code_size = 1;
    for (int i = 0; i < k && code_size <= CODE_LIMIT; i++) code_size *= q;
    // Oversized code or index outside the code: a lone error beat
    if (code_size > CODE_LIMIT || msg >= code_size) begin
      beat = '{symbol: '0, position: '0, last: 1'b0, error: 1'b1};
      codeword_beats_q.push_back(beat);
      return;
    end
    rest = msg;
    for (int i = 0; i < k; i++) begin
      digit[i] = rest % q;
      rest = rest / q;
    end
    for (int j = 0; j < n; j++) begin
      acc = 0;
      for (int i = 0; i < k; i++) acc = (acc + digit[i] * gen_table[i][j]) % q;
      beat.symbol   = acc[SYM_W-1:0];
      beat.position = j[POS_W-1:0];
      beat.last     = (j + 1 == n);
      beat.error    = 1'b0;
      codeword_beats_q.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    codeword_beat_t got, want;
    if (!rst_ni) begin
      length_q = 7;
      dim_q    = 4;
      alph_q   = 2;
      codeword_beats_q.delete();
      mismatch_count_o = 0;
    end else begin
      // Match a result beat against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{symbol:   m_axis_tdata[SYM_W-1:0],
                position: m_axis_tdata[SYM_W+POS_W-1:SYM_W],
                last:     m_axis_tlast,
                error:    m_axis_tuser};
        if (codeword_beats_q.size() == 0) begin
          $display("%0t: unexpected beat: symbol %0d position %0d last %0b error %0b",
                   $time, got.symbol, got.position, got.last, got.error);
          mismatch_count_o++;
        end else begin
          want = codeword_beats_q.pop_front();
          if (got.symbol !== want.symbol || got.position !== want.position ||
              got.last !== want.last || got.error !== want.error) begin
            $display("%0t: beat mismatch: expected symbol %0d position %0d last %0b error %0b",
                     $time, want.symbol, want.position, want.last, want.error);
            $display("%0t:                  actual symbol %0d position %0d last %0b error %0b",
                     $time, got.symbol, got.position, got.last, got.error);
            mismatch_count_o++;
          end
        end
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BLOCK_LENGTH:  length_q = cfg_data_i[BLEN_W-1:0];
          REG_DIMENSION:     dim_q    = cfg_data_i[DIM_W-1:0];
          REG_ALPHABET_SIZE: alph_q   = cfg_data_i[ALPH_W-1:0];
          default: ;
        endcase
      end
      // Apply an input beat: store an entry or queue a codeword
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ITEM_WRITE) begin
          gen_table[s_axis_tdata[ROW_W-1:0]][s_axis_tdata[ROW_W+COL_W-1:ROW_W]] =
            s_axis_tdata[ROW_W+COL_W+ENTRY_W-1:ROW_W+COL_W];
        end else begin
          predict_codeword(s_axis_tdata[S_DATA_W-1:ROW_W+COL_W+ENTRY_W]);
        end
      end
    end
    pending_beats_o = codeword_beats_q.size();
  end

endmodule

>>> dv/tb_generator_matrix_block_encoder_unit.sv
// Testbench top: drives table writes, encodes and code settings, and reports the verdict.
`timescale 1ns / 1ps
module tb_generator_matrix_block_encoder_unit;
  import gmbe_pkg::*;

  localparam int unsigned TARGET_ITEMS  = 310;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned QUIET_LIMIT   = 10000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned sender_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned mismatch_count;
  int unsigned pending_beats;

  always #5 clk_i = ~clk_i;

  generator_matrix_block_encoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  gmbe_codeword_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_beats_o  (pending_beats)
  );

  // Offer one input beat after an optional gap; return at the accepting edge
  task automatic send_beat(item_e kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [ENTRY_W-1:0] value, logic [INDEX_W-1:0] index);
    @(negedge clk_i);
    while (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {index, value, col, row};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
  endtask

  task automatic write_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic [ENTRY_W-1:0] value);
    send_beat(ITEM_WRITE, row, col, value, INDEX_W'($urandom));
  endtask

  task automatic encode_msg(logic [INDEX_W-1:0] index);
    send_beat(ITEM_ENCODE, ROW_W'($urandom), COL_W'($urandom), ENTRY_W'($urandom), index);
  endtask

  // Drop valid, wait for every codeword to arrive, then let the block go idle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Load all three code registers while the block is idle
  task automatic set_code(logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] dim,
                          logic [CFG_DATA_W-1:0] alph);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_BLOCK_LENGTH;
    cfg_data_i  <= len;
    @(negedge clk_i);
    cfg_index_i <= REG_DIMENSION;
    cfg_data_i  <= dim;
    @(negedge clk_i);
    cfg_index_i <= REG_ALPHABET_SIZE;
    cfg_data_i  <= alph;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Stop the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_generator_matrix_block_encoder_unit: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_raw, k_raw, q_raw, k_eff, q_eff, code_size, phase;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ITEM_WRITE;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_BLOCK_LENGTH;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole table so no encode reads an unwritten entry
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 16; c++) begin
        write_entry(ROW_W'(r), COL_W'(c),
                    ($urandom_range(0, 3) == 0) ? 8'hFF : ENTRY_W'($urandom_range(0, 255)));
      end
    end

    // Directed: default code, range edges, index bits all high
    encode_msg(0);
    encode_msg(15);
    encode_msg(16);
    encode_msg(17'h1FFFF);
    write_entry(0, 0, 8'h00);
    write_entry(7, 15, 8'hFF);
    encode_msg(5);
    // Widest binary code
    set_code(16, 8, 2);
    encode_msg(255);
    encode_msg(256);
    encode_msg(170);
    // Single symbol over the largest alphabet
    set_code(1, 1, 256);
    encode_msg(255);
    encode_msg(0);
    // Code size exactly at the limit
    set_code(5, 5, 10);
    encode_msg(99999);
    encode_msg(100000);
    // Code size just past the limit
    set_code(8, 6, 7);
    encode_msg(3);
    // Registers below range saturate upward
    set_code(0, 0, 0);
    encode_msg(1);
    encode_msg(2);
    // Registers above range saturate downward
    set_code(31, 15, 511);
    encode_msg(0);
    set_code(16, 2, 256);
    encode_msg(65535);

    // Random phases: new code, new idling mode, mostly in-range encodes
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      n_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
      k_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      q_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 16);
      set_code(CFG_DATA_W'(n_raw), CFG_DATA_W'(k_raw), CFG_DATA_W'(q_raw));
      k_eff = (k_raw < 1) ? 1 : ((k_raw > 8) ? 8 : k_raw);
      q_eff = (q_raw < 2) ? 2 : ((q_raw > 256) ? 256 : q_raw);
      code_size = 1;
      for (int i = 0; i < k_eff && code_size <= CODE_LIMIT; i++) code_size *= q_eff;
      case (phase % 4)
        0: begin sender_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_gap_pct = 49; sink_stall_pct = 0;  end
        2: begin sender_gap_pct = 0;  sink_stall_pct = 49; end
        default: begin sender_gap_pct = 19; sink_stall_pct = 19; end
      endcase
      // Back up the block once while the sender keeps offering
      if (phase == 4) hold_req = 1'b1;
      repeat (24) begin
        if (items_sent < TARGET_ITEMS) begin
          if ($urandom_range(0, 4) == 0)
            write_entry(ROW_W'($urandom), COL_W'($urandom), ENTRY_W'($urandom));
          else if (code_size <= CODE_LIMIT && $urandom_range(0, 3) != 0)
            encode_msg(INDEX_W'($urandom_range(0, code_size - 1)));
          else encode_msg(INDEX_W'($urandom));
        end
      end
      phase++;
    end

    drain_results();
    if (mismatch_count == 0 && pending_beats == 0)
      $display("tb_generator_matrix_block_encoder_unit: done, clean");
    else
      $display("tb_generator_matrix_block_encoder_unit: done, errors");
    $finish;
  end

endmodule
